/* hdl/rate_limit_lowpass_average_chain_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the smoothing chain
// Each macro expands to one labelled concurrent assertion on the rising
// clock edge, switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef RATE_LIMIT_LOWPASS_AVERAGE_CHAIN_TOP_ASSERT_SVH
`define RATE_LIMIT_LOWPASS_AVERAGE_CHAIN_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLAC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smoothing chain check failed");

// Consequent must hold in the cycle after the antecedent.
`define RLAC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smoothing chain check failed");

`endif

/* hdl/rlac_pkg.sv */
// ----------------------------------------------------------------------------
// rlac_pkg
// Widths, constants and register codes for the slew / low-pass / average chain.
// ----------------------------------------------------------------------------
package rlac_pkg;

   localparam int unsigned SAMPLE_W   = 16;  // signed raw sample
   localparam int unsigned FILT_W     = 32;  // signed Q16.16 result
   localparam int unsigned GAIN_W     = 17;  // unsigned Q1.16, 1.0 included
   localparam int unsigned STEP_W     = 16;  // unsigned slew step
   localparam int unsigned FRAC_W     = 16;  // fraction bits of Q16.16
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam int unsigned WINDOW_LEN_DEFAULT = 8;

   localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'h1_0000;
   localparam logic [STEP_W-1:0] STEP_RESET = 16'hFFFF;

   // Register index, taken from paddr[2] (registers at byte 0 and 4)
   typedef enum logic [0:0] {
      CSR_GAIN = 1'b0,
      CSR_STEP = 1'b1
   } csr_index_type;

endpackage

/* hdl/rate_limit_lowpass_average_chain_top.sv */
// ----------------------------------------------------------------------------
// rate_limit_lowpass_average_chain_top: slew limiter, EMA low-pass, moving average
// Pipeline: input transfer to registered result through 4 stages (A, B, C, D).
// Throughput: one sample per cycle unless stalled; each stage holds one item and a stalled
// result ripples back stage by stage. Reset: synchronous, clears valids and filter state.
// ----------------------------------------------------------------------------
module rate_limit_lowpass_average_chain_top #(
   parameter int unsigned WINDOW_LEN = rlac_pkg::WINDOW_LEN_DEFAULT  // power of two
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [rlac_pkg::SAMPLE_W-1:0]  req_sample,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [rlac_pkg::FILT_W-1:0]    rsp_filtered,
   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rlac_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [rlac_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [rlac_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int unsigned SHIFT_W = $clog2(WINDOW_LEN);
   localparam int unsigned POS_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int unsigned TOT_W   = rlac_pkg::FILT_W + SHIFT_W;
   localparam int unsigned DIFF_W  = rlac_pkg::SAMPLE_W + 2;
   localparam int unsigned D_W     = rlac_pkg::FILT_W + 1;
   localparam int unsigned PROD_W  = rlac_pkg::GAIN_W + 1 + D_W;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic [rlac_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic [rlac_pkg::STEP_W-1:0] step_ff;
   logic                        csr_write;
   rlac_pkg::csr_index_type     csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = rlac_pkg::csr_index_type'(csr_paddr[2]);

   // clamp the gain to 1.0 on the way in
   always_comb begin
      if (csr_pwdata[rlac_pkg::GAIN_W-1:0] > rlac_pkg::GAIN_ONE) begin
         gain_in = rlac_pkg::GAIN_ONE;
      end else begin
         gain_in = csr_pwdata[rlac_pkg::GAIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= rlac_pkg::GAIN_ONE;
         step_ff <= rlac_pkg::STEP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            rlac_pkg::CSR_GAIN: gain_ff <= gain_in;
            rlac_pkg::CSR_STEP: step_ff <= csr_pwdata[rlac_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         rlac_pkg::CSR_GAIN:
            csr_prdata = rlac_pkg::CSR_DATA_W'(gain_ff);
         rlac_pkg::CSR_STEP:
            csr_prdata = rlac_pkg::CSR_DATA_W'(step_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // -------------------------------------------------------------------------
   // Pipeline flow control
   // Four stages: A input register, B slew limiter, C low-pass, D result.
   // A stage takes a new item when it is empty or its item moves on in the
   // same cycle, so a stalled result does not block the stages behind it
   // until they too are full.
   // -------------------------------------------------------------------------
   logic a_valid_ff, b_valid_ff, c_valid_ff, rsp_valid_ff;
   logic a_load, a_to_b, b_to_c, c_to_d;
   logic a_free, b_free, c_free, d_free;

   assign d_free    = !rsp_valid_ff || !rsp_stall;
   assign c_to_d    = c_valid_ff && d_free;
   assign c_free    = !c_valid_ff || d_free;
   assign b_to_c    = b_valid_ff && c_free;
   assign b_free    = !b_valid_ff || c_free;
   assign a_to_b    = a_valid_ff && b_free;
   assign a_free    = !a_valid_ff || b_free;
   assign req_stall = !a_free;
   assign a_load    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_free) begin
            a_valid_ff <= a_load;
         end
         if (b_free) begin
            b_valid_ff <= a_to_b;
         end
         if (c_free) begin
            c_valid_ff <= b_to_c;
         end
         if (d_free) begin
            rsp_valid_ff <= c_to_d;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stage A: input register
   // -------------------------------------------------------------------------
   logic signed [rlac_pkg::SAMPLE_W-1:0] a_sample_ff;

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_sample_ff <= req_sample;
      end
   end

   // -------------------------------------------------------------------------
   // Stage B: slew limiter. limited_ff is both the held value and the
   // payload of stage B. The step never overshoots the sample, so the
   // result always fits the sample width.
   // -------------------------------------------------------------------------
   logic signed [rlac_pkg::SAMPLE_W-1:0] limited_ff, limited_in;
   logic signed [DIFF_W-1:0]             slew_diff, slew_step, lim_up, lim_dn;
   logic                                 lim_zero_pass;

   assign lim_zero_pass = (limited_ff == '0) && (a_sample_ff != '0);

   always_comb begin
      slew_diff = DIFF_W'(a_sample_ff) - DIFF_W'(limited_ff);
      slew_step = $signed({2'b00, step_ff});
      lim_up    = DIFF_W'(limited_ff) + slew_step;
      lim_dn    = DIFF_W'(limited_ff) - slew_step;
      if (lim_zero_pass) begin
         // held zero: take the sample as it is
         limited_in = a_sample_ff;
      end else if (slew_diff > slew_step) begin
         limited_in = lim_up[rlac_pkg::SAMPLE_W-1:0];
      end else if (slew_diff < -slew_step) begin
         limited_in = lim_dn[rlac_pkg::SAMPLE_W-1:0];
      end else begin
         limited_in = a_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limited_ff <= '0;
      end else if (a_to_b) begin
         limited_ff <= limited_in;
      end
   end

   // -------------------------------------------------------------------------
   // Stage C: exponential low-pass in Q16.16.
   //    s' = floor((g*x + (1-g)*s)) = s + floor(g*(x - s) / 2^16)
   // which needs one 18 x 33 multiply; the arithmetic shift floors.
   // -------------------------------------------------------------------------
   logic signed [rlac_pkg::FILT_W-1:0] smoothed_ff, smoothed_in, lp_xq;
   logic signed [D_W-1:0]              lp_diff;
   logic signed [PROD_W-1:0]           lp_prod, lp_sum;

   always_comb begin
      lp_xq   = $signed({limited_ff, {rlac_pkg::FRAC_W{1'b0}}});
      lp_diff = D_W'(lp_xq) - D_W'(smoothed_ff);
      lp_prod = $signed({1'b0, gain_ff}) * lp_diff;
      lp_sum  = PROD_W'(smoothed_ff) + (lp_prod >>> rlac_pkg::FRAC_W);
      if (smoothed_ff == '0 && limited_ff != '0) begin
         // held zero: take the scaled limited value as it is
         smoothed_in = lp_xq;
      end else begin
         smoothed_in = lp_sum[rlac_pkg::FILT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothed_ff <= '0;
      end else if (b_to_c) begin
         smoothed_ff <= smoothed_in;
      end
   end

   // -------------------------------------------------------------------------
   // Window store. The entry an item will overwrite is read as it enters
   // stage C, so the old value is registered by the time the item reaches
   // the average. Valid bits stand for the cleared store after reset; an
   // invalid entry reads as zero. When the item leaving C writes the very
   // entry that the incoming item reads (single-entry window), forward it.
   // -------------------------------------------------------------------------
   logic signed [rlac_pkg::FILT_W-1:0] win_mem [WINDOW_LEN];
   logic [WINDOW_LEN-1:0]              win_valid_ff;
   logic [POS_W-1:0]                   pos_ff, pos_next, rd_addr;
   logic                               rd_forward;
   logic signed [rlac_pkg::FILT_W-1:0] old_ff;

   assign pos_next   = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
   assign rd_addr    = c_to_d ? pos_next : pos_ff;
   assign rd_forward = c_to_d && (rd_addr == pos_ff);

   always_ff @(posedge clock) begin
      if (c_to_d) begin
         win_mem[pos_ff] <= smoothed_ff;
      end
      if (b_to_c) begin
         if (rd_forward) begin
            old_ff <= smoothed_ff;
         end else if (win_valid_ff[rd_addr]) begin
            old_ff <= win_mem[rd_addr];
         end else begin
            old_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= '0;
         pos_ff       <= '0;
      end else if (c_to_d) begin
         win_valid_ff[pos_ff] <= 1'b1;
         pos_ff               <= pos_next;
      end
   end

   // -------------------------------------------------------------------------
   // Stage D: running total and average (arithmetic shift floors)
   // -------------------------------------------------------------------------
   logic signed [TOT_W-1:0]           total_ff, total_in, avg_full;
   logic signed [rlac_pkg::FILT_W-1:0] filtered_ff;

   always_comb begin
      total_in = total_ff - TOT_W'(old_ff) + TOT_W'(smoothed_ff);
      avg_full = total_in >>> SHIFT_W;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (c_to_d) begin
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (c_to_d) begin
         filtered_ff <= avg_full[rlac_pkg::FILT_W-1:0];
      end
   end

   assign rsp_filtered = filtered_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
`include "rate_limit_lowpass_average_chain_top_assert.svh"

   // held zero passes a nonzero sample straight through
   `RLAC_ASSERT_NEXT(a_zero_hold_pass, a_to_b && lim_zero_pass, limited_ff == $past(a_sample_ff))
   // the input side only stalls when the input register is occupied
   `RLAC_ASSERT_SAME(a_stall_needs_item, req_stall, a_valid_ff)
   // a gain write never leaves the gain above one
   `RLAC_ASSERT_NEXT(a_gain_clamped, csr_write, gain_ff <= rlac_pkg::GAIN_ONE)

endmodule
